// ===== src/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpp_pkg: shared types and constants for the convex polygon point test
// Fixed-point widths, item kinds, config indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none
package cpp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VW           = $clog2(MAX_VERTICES);
  localparam int CW           = $clog2(MAX_VERTICES + 1);
  localparam int CNTW         = (CW > 5) ? CW : 5;
  localparam int CORDIC_STEPS = 16;
  localparam int SW           = $clog2(CORDIC_STEPS);
  localparam int QDEPTH       = 2;
  localparam int QPW          = 1;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // config register indexes
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_ROTATION = 3'd2;
  localparam logic [2:0] REG_SCALE    = 3'd3;
  localparam logic [2:0] REG_VCOUNT   = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         slot;
    logic [31:0]        radius;
    logic [15:0]        angle;   // heading plus rotation, mod one turn
    logic signed [31:0] qx;
    logic signed [31:0] qy;
  } item_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [15:0]        scale;
    logic [4:0]         vcount;
  } cfg_t;

  // atan(2^-i) in units of 2^-24 turn
  function automatic logic signed [24:0] atan_tab(input logic [SW-1:0] i);
    logic signed [24:0] v;
    case (i)
      4'd0:    v = 25'sd2097152;
      4'd1:    v = 25'sd1238021;
      4'd2:    v = 25'sd654136;
      4'd3:    v = 25'sd332050;
      4'd4:    v = 25'sd166669;
      4'd5:    v = 25'sd83416;
      4'd6:    v = 25'sd41718;
      4'd7:    v = 25'sd20860;
      4'd8:    v = 25'sd10430;
      4'd9:    v = 25'sd5215;
      4'd10:   v = 25'sd2608;
      4'd11:   v = 25'sd1304;
      4'd12:   v = 25'sd652;
      4'd13:   v = 25'sd326;
      4'd14:   v = 25'sd163;
      default: v = 25'sd81;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/cpp_front.sv =====
// ----------------------------------------------------------------------------
// cpp_front: command intake and queue
// Classifies each accepted command, folds the rotation into the angle and
// queues it for the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none
module cpp_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire                 command,
  input  wire  [3:0]          vertex_slot,
  input  wire  [31:0]         vertex_radius,
  input  wire  [15:0]         vertex_heading,
  input  wire  signed [31:0]  query_x,
  input  wire  signed [31:0]  query_y,
  input  wire  [15:0]         rotation,
  output logic                q_valid,
  output cpp_pkg::item_t      q_item,
  input  wire                 q_pop
);

  cpp_pkg::item_t      fifo [cpp_pkg::QDEPTH];
  logic [cpp_pkg::QPW-1:0] wp, rp;
  logic [cpp_pkg::QPW:0]   count;
  cpp_pkg::item_t      itm;
  logic                push;

  always_comb begin
    itm.slot   = vertex_slot;
    itm.radius = vertex_radius;
    itm.angle  = vertex_heading + rotation;
    itm.qx     = query_x;
    itm.qy     = query_y;
    if (command == cpp_pkg::CMD_QUERY) begin
      itm.kind = cpp_pkg::KIND_QUERY;
    end else if ({1'b0, vertex_slot} >= 5'(cpp_pkg::MAX_VERTICES)) begin
      itm.kind = cpp_pkg::KIND_DROP;
    end else begin
      itm.kind = cpp_pkg::KIND_LOAD;
    end
  end

  assign busy    = (count == (cpp_pkg::QPW+1)'(cpp_pkg::QDEPTH));
  assign push    = start && !busy && (itm.kind != cpp_pkg::KIND_DROP);
  assign q_valid = (count != '0);
  assign q_item  = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= itm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (q_pop) rp <= rp + 1'b1;
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (cpp_pkg::QPW+1)'(cpp_pkg::QDEPTH))
    else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== src/cpp_back.sv =====
// ----------------------------------------------------------------------------
// cpp_back: execution engine
// Loads: CORDIC, scaling and placement of one vertex. Queries: edge walk with
// cross product sign over the stored vertices, one partial product a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cpp_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire cpp_pkg::cfg_t  cfg,
  input  wire                 q_valid,
  input  wire cpp_pkg::item_t q_item,
  output logic                q_pop,
  output logic                done,
  output logic                inside_res
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CORDIC = 4'd1;
  localparam logic [3:0] S_ROT    = 4'd2;
  localparam logic [3:0] S_M0     = 4'd3;
  localparam logic [3:0] S_M1     = 4'd4;
  localparam logic [3:0] S_FIN    = 4'd5;
  localparam logic [3:0] S_QRD    = 4'd6;
  localparam logic [3:0] S_QDIF   = 4'd7;
  localparam logic [3:0] S_QP0    = 4'd8;
  localparam logic [3:0] S_QP1    = 4'd9;
  localparam logic [3:0] S_QP2    = 4'd10;
  localparam logic [3:0] S_QP3    = 4'd11;
  localparam logic [3:0] S_QSGN   = 4'd12;

  logic [3:0]               state;
  logic [cpp_pkg::SW-1:0]   step;
  logic signed [32:0]       cx, cy;
  logic signed [24:0]       cz;
  logic [1:0]               quad;
  logic [39:0]              mag;
  logic signed [25:0]       tc, ts;
  logic signed [67:0]       acc;
  logic                     sel;
  logic signed [31:0]       wx;
  logic [cpp_pkg::VW-1:0]   slot;
  logic signed [31:0]       qx, qy;
  logic [cpp_pkg::CNTW-1:0] nv;
  logic [cpp_pkg::VW-1:0]   ei;
  logic [cpp_pkg::VW-1:0]   ej;
  logic                     last;
  logic                     seen_l, seen_r;
  logic signed [32:0]       dx, dy, ex, ey;

  logic signed [31:0] mem_x [cpp_pkg::MAX_VERTICES];
  logic signed [31:0] mem_y [cpp_pkg::MAX_VERTICES];
  logic signed [31:0] rx1, ry1, rx2, ry2;
  logic               we;
  logic signed [31:0] wy;

  // combinational helpers
  logic [15:0]              a_q;
  logic [1:0]               q0;
  logic [15:0]              resid;
  logic [cpp_pkg::CNTW-1:0] nsat;
  logic signed [32:0]       sdx, sdy;
  logic signed [33:0]       c34, s34;
  logic signed [25:0]       tsel;
  logic signed [67:0]       offv, sumv;
  logic signed [31:0]       satv;
  logic signed [31:0]       ctr;
  logic                     is_left;

  assign q_pop = q_valid && (state == S_IDLE);

  always_comb begin
    a_q   = q_item.angle + 16'h2000;
    q0    = a_q[15:14];
    resid = q_item.angle - {q0, 14'd0};
    nsat  = (cpp_pkg::CNTW'(cfg.vcount) > cpp_pkg::CNTW'(cpp_pkg::MAX_VERTICES)) ?
            cpp_pkg::CNTW'(cpp_pkg::MAX_VERTICES) : cpp_pkg::CNTW'(cfg.vcount);
    last  = ((cpp_pkg::CNTW'(ei) + 1'b1) == nv);
    ej    = last ? '0 : ei + 1'b1;
    sdx   = cy >>> step;
    sdy   = cx >>> step;
    case (quad)
      2'd0:    begin c34 = 34'(cx);  s34 = 34'(cy);  end
      2'd1:    begin c34 = -34'(cy); s34 = 34'(cx);  end
      2'd2:    begin c34 = -34'(cx); s34 = -34'(cy); end
      default: begin c34 = 34'(cy);  s34 = -34'(cx); end
    endcase
    tsel  = sel ? ts : tc;
    ctr   = sel ? cfg.center_y : cfg.center_x;
    offv  = (acc + 68'sd2097152) >>> 22;
    sumv  = 68'(ctr) + offv;
    if (sumv > 68'sd2147483647) begin
      satv = 32'sh7fffffff;
    end else if (sumv < -68'sd2147483648) begin
      satv = 32'sh80000000;
    end else begin
      satv = sumv[31:0];
    end
    is_left = (acc > 68'sd0);
    we      = (state == S_FIN) && sel;
    wy      = satv;
  end

  // vertex store, registered reads at the two ends of the current edge
  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[slot] <= wx;
      mem_y[slot] <= wy;
    end
    rx1 <= mem_x[ei];
    ry1 <= mem_y[ei];
    rx2 <= mem_x[ej];
    ry2 <= mem_y[ej];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          slot <= q_item.slot[cpp_pkg::VW-1:0];
          qx   <= q_item.qx;
          qy   <= q_item.qy;
          nv   <= nsat;
          ei   <= '0;
          cx   <= 33'sd652032874;
          cy   <= '0;
          cz   <= 25'($signed(resid)) <<< 8;
          quad <= q0;
          mag  <= 40'((48'(q_item.radius) * 48'(cfg.scale)) >> 8);
          sel  <= 1'b0;
        end
      end
      S_CORDIC: begin
        if (cz >= 0) begin
          cx <= cx - sdx;
          cy <= cy + sdy;
          cz <= cz - cpp_pkg::atan_tab(step);
        end else begin
          cx <= cx + sdx;
          cy <= cy - sdy;
          cz <= cz + cpp_pkg::atan_tab(step);
        end
      end
      S_ROT: begin
        tc <= 26'((c34 + 34'sd128) >>> 8);
        ts <= 26'((s34 + 34'sd128) >>> 8);
      end
      S_M0: acc <= $signed({1'b0, mag[19:0]}) * tsel;
      S_M1: acc <= acc + (($signed({1'b0, mag[39:20]}) * tsel) <<< 20);
      S_FIN: begin
        if (!sel) begin
          wx  <= satv;
          sel <= 1'b1;
        end
      end
      S_QDIF: begin
        dx <= 33'(rx2) - 33'(rx1);
        dy <= 33'(ry2) - 33'(ry1);
        ex <= 33'(qx) - 33'(rx1);
        ey <= 33'(qy) - 33'(ry1);
      end
      S_QP0: acc <= $signed({1'b0, dx[16:0]}) * ey;
      S_QP1: acc <= acc + (($signed(dx[32:17]) * ey) <<< 17);
      S_QP2: acc <= acc - ($signed({1'b0, dy[16:0]}) * ex);
      S_QP3: acc <= acc - (($signed(dy[32:17]) * ex) <<< 17);
      S_QSGN: begin
        if (!last) ei <= ei + 1'b1;
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      done       <= 1'b0;
      inside_res <= 1'b0;
      seen_l     <= 1'b0;
      seen_r     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            seen_l <= 1'b0;
            seen_r <= 1'b0;
            step   <= '0;
            if (q_item.kind == cpp_pkg::KIND_QUERY) begin
              if (nsat == '0) begin
                done       <= 1'b1;
                inside_res <= 1'b0;
              end else begin
                state <= S_QRD;
              end
            end else begin
              state <= S_CORDIC;
            end
          end
        end
        S_CORDIC: begin
          step <= step + 1'b1;
          if (step == cpp_pkg::SW'(cpp_pkg::CORDIC_STEPS - 1)) state <= S_ROT;
        end
        S_ROT:  state <= S_M0;
        S_M0:   state <= S_M1;
        S_M1:   state <= S_FIN;
        S_FIN:  state <= sel ? S_IDLE : S_M0;
        S_QRD:  state <= S_QDIF;
        S_QDIF: state <= S_QP0;
        S_QP0:  state <= S_QP1;
        S_QP1:  state <= S_QP2;
        S_QP2:  state <= S_QP3;
        S_QP3:  state <= S_QSGN;
        S_QSGN: begin
          seen_l <= seen_l | is_left;
          seen_r <= seen_r | !is_left;
          if (last) begin
            done       <= 1'b1;
            inside_res <= !((seen_l | is_left) && (seen_r | !is_left));
            state      <= S_IDLE;
          end else begin
            state <= S_QRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    state <= S_QSGN)
    else $error("illegal engine state");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result while engine busy");
  a_write_load: assert property (@(posedge clk) disable iff (rst)
    we |-> $past(state) == S_M1)
    else $error("vertex write out of sequence");

endmodule
`default_nettype wire

// ===== src/convex_polygon_point_test.sv =====
// ----------------------------------------------------------------------------
// convex_polygon_point_test: point in convex polygon test, fixed point
// Vertex loader (polar to world via CORDIC) and edge-sign query engine.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high
//   and busy low. command selects load (write one vertex) or query.
//   Commands pass through a two-entry queue into the execution engine, so
//   busy rises only when that queue is full; an idle engine takes a command
//   from the queue in the cycle after it is taken.
//   Load: 16 CORDIC steps plus rotate, two partial products and a saturating
//   add per coordinate in the engine; no result.
//   Query: per edge a read, the differences, four partial products of the
//   exact cross product in a 68-bit accumulator and a sign step, over the n
//   stored vertices; an empty polygon is answered from idle as outside.
//   Result: done pulses for one cycle with inside_res; the receiver cannot
//   stall, so every result is taken on that cycle.
//   Config channel: cfg_valid/cfg_ready, always ready; cfg_index selects the
//   register, cfg_data carries the value (low bits used). Write only while
//   idle.
//   Reset (rst, synchronous): clears queue and engine, config returns to
//   center 0, rotation 0, scale 1.0, vertex count 0. Vertex storage is not
//   cleared; load every vertex used before querying.
// ----------------------------------------------------------------------------
`default_nettype none
module convex_polygon_point_test (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire                command,
  input  wire  [3:0]         vertex_slot,
  input  wire  [31:0]        vertex_radius,
  input  wire  [15:0]        vertex_heading,
  input  wire  signed [31:0] query_x,
  input  wire  signed [31:0] query_y,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [2:0]         cfg_index,
  input  wire  [31:0]        cfg_data,
  output logic               done,
  output logic               inside_res
);

  cpp_pkg::cfg_t  cfg;
  logic [15:0]    rotation;
  logic           q_valid;
  logic           q_pop;
  cpp_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= '0;
      cfg.center_y <= '0;
      rotation     <= '0;
      cfg.scale    <= 16'd256;
      cfg.vcount   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpp_pkg::REG_CENTER_X: cfg.center_x <= cfg_data;
        cpp_pkg::REG_CENTER_Y: cfg.center_y <= cfg_data;
        cpp_pkg::REG_ROTATION: rotation     <= cfg_data[15:0];
        cpp_pkg::REG_SCALE:    cfg.scale    <= cfg_data[15:0];
        cpp_pkg::REG_VCOUNT:   cfg.vcount   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  cpp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .vertex_slot    (vertex_slot),
    .vertex_radius  (vertex_radius),
    .vertex_heading (vertex_heading),
    .query_x        (query_x),
    .query_y        (query_y),
    .rotation       (rotation),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  cpp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .done       (done),
    .inside_res (inside_res)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_convex_polygon_point_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_convex_polygon_point_test: self-checking testbench
// Loads polar vertices and queries points under a series of center, rotation,
// scale and count settings; a cycle-exact-free predictor computes each
// inside/outside answer and the monitor checks every done pulse against it.
// ----------------------------------------------------------------------------
module tb_convex_polygon_point_test;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 150;   // extra wait in drain() after the queues empty
  localparam int ITEM_GOAL   = 1450;

  typedef struct {
    logic               cmd;
    logic [3:0]         slot;
    logic [31:0]        radius;
    logic [15:0]        heading;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
  } poly_cmd_t;

  // atan(2^-i) in 2^-24 turn units
  localparam longint ATAN24 [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                                     41718, 20860, 10430, 5215, 2608, 1304, 652, 326,
                                     163, 81};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               command = cpp_pkg::CMD_LOAD;
  logic [3:0]         vertex_slot = '0;
  logic [31:0]        vertex_radius = '0;
  logic [15:0]        vertex_heading = '0;
  logic signed [31:0] query_x = '0;
  logic signed [31:0] query_y = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = cpp_pkg::REG_CENTER_X;
  logic [31:0]        cfg_data = '0;
  logic               done;
  logic               inside_res;

  convex_polygon_point_test i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .vertex_slot(vertex_slot), .vertex_radius(vertex_radius),
    .vertex_heading(vertex_heading), .query_x(query_x), .query_y(query_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .inside_res(inside_res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: shadow config and world vertex store
  longint             pc_cx, pc_cy;
  logic [15:0]        pc_rot, pc_scale;
  logic [4:0]         pc_count;
  logic signed [31:0] vtx_x [cpp_pkg::MAX_VERTICES];
  logic signed [31:0] vtx_y [cpp_pkg::MAX_VERTICES];

  poly_cmd_t pending_q [$];
  bit        inside_q [$];
  poly_cmd_t on_bus;
  bit        gaps_on = 1'b1;
  int        errors = 0, n_loads = 0, n_queries = 0, n_checked = 0, n_inside = 0;
  int        n_pushed = 0, n_phases = 0;
  longint    cycles = 0;

  // cos/sin in Q2.30 of a 16-bit turn angle: quadrant fold then 16 CORDIC steps
  function automatic void cordic_trig(input logic [15:0] ang, output longint c,
                                      output longint s);
    longint             x, y, z, dx, dy;
    int unsigned        quad;
    logic [15:0]        resid;
    logic signed [15:0] rs;
    quad  = ((32'(ang) + 32'h2000) >> 14) & 3;
    resid = ang - 16'(quad * 16384);
    rs    = resid;
    z     = longint'(rs) * 256;
    x     = 652032874;
    y     = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ATAN24[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ATAN24[i];
      end
    end
    case (quad)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // center + round(m * trig), trig rounded to Q2.22 first
  function automatic logic signed [31:0] place_coord(input longint ctr, input longint mag,
                                                     input longint t30);
    logic signed [127:0] t22, mm, off, cc;
    t22 = (t30 + 128) >>> 8;
    mm  = mag;
    cc  = ctr;
    off = (mm * t22 + 128'sd2097152) >>> 22;
    return clamp32(cc + off);
  endfunction

  function automatic void polar_to_world(input logic [31:0] rad, input logic [15:0] hd,
                                         output logic signed [31:0] wx,
                                         output logic signed [31:0] wy);
    longint      c, s, mag;
    logic [15:0] ang;
    ang = hd + pc_rot;
    mag = longint'((64'(rad) * 64'(pc_scale)) >> 8);
    cordic_trig(ang, c, s);
    wx = place_coord(pc_cx, mag, c);
    wy = place_coord(pc_cy, mag, s);
  endfunction

  // all edge cross products strictly positive, or all zero/negative
  function automatic bit point_inside(input logic signed [31:0] px,
                                      input logic signed [31:0] py);
    int                  nv, lefts, rights, j;
    logic signed [127:0] ex, ey, dx, dy, cr;
    nv = (pc_count > cpp_pkg::MAX_VERTICES) ? cpp_pkg::MAX_VERTICES : pc_count;
    lefts = 0;
    rights = 0;
    for (int i = 0; i < nv; i++) begin
      j  = (i + 1 == nv) ? 0 : i + 1;
      ex = vtx_x[j]; ex = ex - vtx_x[i];
      ey = vtx_y[j]; ey = ey - vtx_y[i];
      dx = px;       dx = dx - vtx_x[i];
      dy = py;       dy = dy - vtx_y[i];
      cr = ex * dy - ey * dx;
      if (cr > 0) lefts++;
      else rights++;
    end
    return (nv != 0) && (lefts == 0 || rights == 0);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("ERROR t=%0t %s", $realtime, what);
  endtask

  // driver: a transaction completes on start && !busy; hold while busy
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (on_bus.cmd == cpp_pkg::CMD_LOAD) begin
          polar_to_world(on_bus.radius, on_bus.heading, vtx_x[on_bus.slot],
                         vtx_y[on_bus.slot]);
          n_loads++;
        end else begin
          inside_q = {inside_q, point_inside(on_bus.qx, on_bus.qy)};
          n_queries++;
        end
      end
      if (!(start && busy)) begin
        if (pending_q.size() > 0 && !(gaps_on && $urandom_range(99) < 20)) begin
          on_bus         = pending_q.pop_front();
          start          <= 1'b1;
          command        <= on_bus.cmd;
          vertex_slot    <= on_bus.slot;
          vertex_radius  <= on_bus.radius;
          vertex_heading <= on_bus.heading;
          query_x        <= on_bus.qx;
          query_y        <= on_bus.qy;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done pulse is one result, checked against the oldest prediction
  always @(posedge clk) begin
    bit want;
    if (!rst && done) begin
      if (inside_q.size() == 0) begin
        report_mismatch("result with no query outstanding");
      end else begin
        want = inside_q.pop_front();
        n_checked++;
        if (want) n_inside++;
        if (inside_res !== want)
          report_mismatch($sformatf("inside_res %b, predicted %b", inside_res, want));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("convex_polygon_point_test: mismatch");
      $finish;
    end
  end

  task automatic push_load(input int slot, input logic [31:0] rad, input logic [15:0] hd);
    poly_cmd_t it;
    it = '{cmd: cpp_pkg::CMD_LOAD, slot: 4'(slot), radius: rad, heading: hd,
           qx: $urandom, qy: $urandom};
    pending_q = {pending_q, it};
    n_pushed++;
  endtask

  task automatic push_query(input logic signed [31:0] x, input logic signed [31:0] y);
    poly_cmd_t it;
    it = '{cmd: cpp_pkg::CMD_QUERY, slot: 4'($urandom), radius: $urandom,
           heading: 16'($urandom), qx: x, qy: y};
    pending_q = {pending_q, it};
    n_pushed++;
  endtask

  // sender pauses here until the block has nothing left in flight
  task automatic drain();
    while (pending_q.size() != 0 || start || inside_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write one register; valid stays up for a back-to-back write, caller lowers it
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cpp_pkg::REG_CENTER_X: pc_cx = longint'(signed'(val));
      cpp_pkg::REG_CENTER_Y: pc_cy = longint'(signed'(val));
      cpp_pkg::REG_ROTATION: pc_rot = val[15:0];
      cpp_pkg::REG_SCALE:    pc_scale = val[15:0];
      cpp_pkg::REG_VCOUNT:   pc_count = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [15:0] rot, input logic [15:0] scl,
                            input logic [4:0] cnt);
    write_reg(cpp_pkg::REG_CENTER_X, cx);
    write_reg(cpp_pkg::REG_CENTER_Y, cy);
    write_reg(cpp_pkg::REG_ROTATION, {16'($urandom), rot});  // upper bits are don't-care
    write_reg(cpp_pkg::REG_SCALE, {16'($urandom), scl});
    write_reg(cpp_pkg::REG_VCOUNT, {27'($urandom), cnt});
    cfg_valid <= 1'b0;
    n_phases++;
  endtask

  function automatic longint spread(input longint span);
    longint unsigned r;
    r = {$urandom, $urandom};
    return longint'(r % longint'(2 * span + 1)) - span;
  endfunction

  // one random phase: new setting, mostly a regular convex ring, then probe points
  task automatic random_phase();
    logic [31:0]        cx, cy, base_r, rad;
    logic [15:0]        rot, scl, hd;
    logic [4:0]         cnt;
    int                 ring, pick, a, b;
    longint             reach, px, py;
    logic signed [31:0] bx [cpp_pkg::MAX_VERTICES];
    logic signed [31:0] by [cpp_pkg::MAX_VERTICES];
    drain();
    pick = $urandom_range(99);
    cx = (pick < 80) ? 32'(spread(1 << 24)) : $urandom;
    cy = (pick < 80) ? 32'(spread(1 << 24)) : $urandom;
    if (pick >= 95) begin
      cx = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      cy = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
    end
    rot = 16'($urandom);
    pick = $urandom_range(99);
    scl = (pick < 75) ? 16'($urandom_range(1024, 64)) :
          (pick < 85) ? 16'h0000 : (pick < 92) ? 16'hFFFF : 16'($urandom);
    pick = $urandom_range(99);
    cnt = (pick < 80) ? 5'($urandom_range(16, 3)) : 5'($urandom_range(31));
    set_config(cx, cy, rot, scl, cnt);

    ring   = (cnt == 0) ? 1 :
             ((cnt > cpp_pkg::MAX_VERTICES) ? cpp_pkg::MAX_VERTICES : cnt);
    base_r = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h400000, 32'h10000);
    for (int k = 0; k < cpp_pkg::MAX_VERTICES; k++) begin
      if ($urandom_range(99) < 85) begin
        // regular ring order with small jitter keeps it convex
        hd  = 16'((k * 65536) / ring + $urandom_range(255));
        rad = base_r + (base_r >> 6) * $urandom_range(3);
      end else begin
        hd  = 16'($urandom);
        rad = $urandom;
      end
      push_load(k, rad, hd);
      polar_to_world(rad, hd, bx[k], by[k]);
    end
    // an occasional stray reload
    if ($urandom_range(9) == 0) begin
      a = $urandom_range(15);
      rad = $urandom;
      hd = 16'($urandom);
      push_load(a, rad, hd);
      polar_to_world(rad, hd, bx[a], by[a]);
    end

    reach = longint'((64'(base_r) * 64'(scl)) >> 8) * 2 + 1;
    if (reach > 64'sh1_0000_0000) reach = 64'sh1_0000_0000;
    for (int k = 0; k < 32; k++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        a  = $urandom_range(ring - 1);
        b  = (a + 1) % ring;
        px = (pick < 10) ? longint'(bx[a]) : (longint'(bx[a]) + longint'(bx[b])) / 2;
        py = (pick < 10) ? longint'(by[a]) : (longint'(by[a]) + longint'(by[b])) / 2;
      end else if (pick < 35) begin
        px = longint'(signed'($urandom));
        py = longint'(signed'($urandom));
      end else begin
        px = longint'(signed'(cx)) + spread(reach);
        py = longint'(signed'(cy)) + spread(reach);
      end
      push_query(clamp32(px), clamp32(py));
    end
  endtask

  localparam logic [31:0] EDGE_RADIUS [16] = '{
    32'h0, 32'hFFFFFFFF, 32'h10000, 32'h1, 32'h80000000, 32'h7FFFFFFF, 32'h20000,
    32'h100000, 32'hFFFF, 32'h5555AAAA, 32'hAAAA5555, 32'h30000, 32'h1000000,
    32'h40000, 32'h8000, 32'hFFFF0000};
  localparam logic [15:0] EDGE_HEADING [16] = '{
    16'h0000, 16'hFFFF, 16'h2000, 16'h1FFF, 16'h4000, 16'h6000, 16'h8000, 16'h7FFF,
    16'hA000, 16'hC000, 16'hE000, 16'hDFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h3FFF};

  initial begin
    pc_cx = 0;
    pc_cy = 0;
    pc_rot = '0;
    pc_scale = 16'd256;
    pc_count = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty polygon right after reset: answer is outside, no vertex is read
    push_query(32'sh80000000, 32'sh7FFFFFFF);
    drain();

    // every slot loaded at extreme center, rotation and scale; single vertex
    set_config(32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 16'hFFFF, 5'd1);
    for (int k = 0; k < cpp_pkg::MAX_VERTICES; k++)
      push_load(k, EDGE_RADIUS[k], EDGE_HEADING[k]);
    push_query(32'sh0, 32'sh0);
    push_query(32'sh80000000, 32'sh80000000);

    // two-vertex degenerate ring
    drain();
    set_config(32'h0, 32'h0, 16'h0, 16'd256, 5'd2);
    push_query(32'sh7FFFFFFF, 32'sh80000000);
    push_query(32'sh7FFFFFFF, 32'sh7FFFFFFF);

    // count beyond the store saturates to a full ring
    drain();
    set_config(32'h0, 32'h0, 16'h0, 16'd256, 5'd31);
    push_query(32'sh0, 32'sh0);
    push_query(32'sh12345678, -32'sh00ABCDEF);

    while (n_pushed < ITEM_GOAL) begin
      gaps_on = !(n_phases >= 10 && n_phases < 15);   // a gap-free stretch
      random_phase();
    end

    drain();
    $display("%0d loads and %0d queries over %0d settings; %0d answers checked, %0d inside",
             n_loads, n_queries, n_phases, n_checked, n_inside);
    if (errors == 0) begin
      $display("convex_polygon_point_test: match");
    end else begin
      $display("convex_polygon_point_test: mismatch");
    end
    $finish;
  end

endmodule
